// File: rtl/core/umpenc_pkg.sv
`default_nettype none

package umpenc_pkg;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [3:0] FUNC_NOTE_ON    = 4'd0;
  localparam logic [3:0] FUNC_NOTE_OFF   = 4'd1;
  localparam logic [3:0] FUNC_PROGRAM    = 4'd2;
  localparam logic [3:0] FUNC_CC         = 4'd3;
  localparam logic [3:0] FUNC_BEND       = 4'd4;
  localparam logic [3:0] FUNC_CLOCKSTAMP = 4'd5;
  localparam logic [3:0] FUNC_DCTPQ      = 4'd6;
  localparam logic [3:0] FUNC_CLIP_START = 4'd7;
  localparam logic [3:0] FUNC_CLIP_END   = 4'd8;
  localparam logic [3:0] FUNC_TEMPO      = 4'd9;
  localparam logic [3:0] FUNC_TIMESIG    = 4'd10;

  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
  localparam logic [3:0] STATUS_CC       = 4'hB;
  localparam logic [3:0] STATUS_BEND     = 4'hE;

  localparam logic [3:0]  MT_CV          = 4'h2;
  localparam logic [3:0]  MT_FLEX        = 4'hD;
  localparam logic [3:0]  STATUS_STAMP   = 4'h4;
  localparam logic [3:0]  STATUS_DCTPQ   = 4'h3;
  localparam logic [15:0] TICK_CHUNK     = 16'hFFFF;
  localparam logic [13:0] BEND_MAX       = 14'h3FFF;
  localparam logic [31:0] CLIP_START_HDR = 32'hF020_0000;
  localparam logic [31:0] CLIP_END_HDR   = 32'hF021_0000;
  localparam logic [6:0]  TEMPO_SCALE    = 7'd100;

  typedef enum logic [3:0] {
    SEL_CV,
    SEL_STAMP,
    SEL_DCTPQ,
    SEL_CLIP_START,
    SEL_CLIP_END,
    SEL_TEMPO_HEAD,
    SEL_TEMPO_VAL,
    SEL_TSIG_HEAD,
    SEL_TSIG_VAL,
    SEL_ZERO
  } sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_LOOP,
    SEQ_END
  } seq_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    sel_t sel;
    seq_t seq;
    pc_t  target;
  } uword_t;

  typedef struct packed {
    logic run;
    pc_t  pc;
  } entry_t;

  typedef struct packed {
    logic load;
    logic tick_dec;
    sel_t sel;
  } dp_ctl_t;

  localparam pc_t PC_CV         = 4'd0;
  localparam pc_t PC_STAMP      = 4'd1;
  localparam pc_t PC_DCTPQ      = 4'd2;
  localparam pc_t PC_CLIP_START = 4'd3;
  localparam pc_t PC_TAIL       = 4'd4;
  localparam pc_t PC_TAIL_END   = 4'd5;
  localparam pc_t PC_CLIP_END   = 4'd6;
  localparam pc_t PC_TEMPO      = 4'd7;
  localparam pc_t PC_TEMPO_VAL  = 4'd8;
  localparam pc_t PC_TSIG       = 4'd9;
  localparam pc_t PC_TSIG_VAL   = 4'd10;
  localparam pc_t PC_CLIP_PAD   = 4'd11;

  // Every step emits one word; the four-word events share a two-word zero tail.
  function automatic uword_t ucode(input pc_t pc);
    uword_t uw;
    case (pc)
      PC_CV:         uw = '{sel: SEL_CV,         seq: SEQ_END,  target: PC_CV};
      PC_STAMP:      uw = '{sel: SEL_STAMP,      seq: SEQ_LOOP, target: PC_STAMP};
      PC_DCTPQ:      uw = '{sel: SEL_DCTPQ,      seq: SEQ_END,  target: PC_DCTPQ};
      PC_CLIP_START: uw = '{sel: SEL_CLIP_START, seq: SEQ_JUMP, target: PC_CLIP_PAD};
      PC_TAIL:       uw = '{sel: SEL_ZERO,       seq: SEQ_NEXT, target: PC_TAIL};
      PC_TAIL_END:   uw = '{sel: SEL_ZERO,       seq: SEQ_END,  target: PC_TAIL_END};
      PC_CLIP_END:   uw = '{sel: SEL_CLIP_END,   seq: SEQ_JUMP, target: PC_CLIP_PAD};
      PC_TEMPO:      uw = '{sel: SEL_TEMPO_HEAD, seq: SEQ_NEXT, target: PC_TEMPO};
      PC_TEMPO_VAL:  uw = '{sel: SEL_TEMPO_VAL,  seq: SEQ_JUMP, target: PC_TAIL};
      PC_TSIG:       uw = '{sel: SEL_TSIG_HEAD,  seq: SEQ_NEXT, target: PC_TSIG};
      PC_TSIG_VAL:   uw = '{sel: SEL_TSIG_VAL,   seq: SEQ_JUMP, target: PC_TAIL};
      PC_CLIP_PAD:   uw = '{sel: SEL_ZERO,       seq: SEQ_JUMP, target: PC_TAIL};
      default:       uw = '{sel: SEL_ZERO,       seq: SEQ_END,  target: PC_CV};
    endcase
    return uw;
  endfunction

  function automatic entry_t entry(input logic [3:0] f);
    entry_t e;
    case (f)
      FUNC_NOTE_ON, FUNC_NOTE_OFF, FUNC_PROGRAM, FUNC_CC, FUNC_BEND:
        e = '{run: 1'b1, pc: PC_CV};
      FUNC_CLOCKSTAMP: e = '{run: 1'b1, pc: PC_STAMP};
      FUNC_DCTPQ:      e = '{run: 1'b1, pc: PC_DCTPQ};
      FUNC_CLIP_START: e = '{run: 1'b1, pc: PC_CLIP_START};
      FUNC_CLIP_END:   e = '{run: 1'b1, pc: PC_CLIP_END};
      FUNC_TEMPO:      e = '{run: 1'b1, pc: PC_TEMPO};
      FUNC_TIMESIG:    e = '{run: 1'b1, pc: PC_TSIG};
      default:         e = '{run: 1'b0, pc: PC_CV};
    endcase
    return e;
  endfunction

  // Number of thirty-second notes in one beat of the given denominator.
  function automatic logic [7:0] thirty_seconds(input logic [7:0] d);
    logic [7:0] n;
    case (d) inside
      8'd1:         n = 8'd32;
      8'd2:         n = 8'd16;
      8'd3:         n = 8'd10;
      8'd4:         n = 8'd8;
      8'd5:         n = 8'd6;
      8'd6:         n = 8'd5;
      [8'd7:8'd8]:  n = 8'd4;
      [8'd9:8'd10]: n = 8'd3;
      [8'd11:8'd16]: n = 8'd2;
      [8'd17:8'd32]: n = 8'd1;
      default:      n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] floor_log2(input logic [7:0] d);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (d[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ump_event_word_encoder.sv
// An accepted item starts the sequencer, which registers its first word at the output.
// The microcode sequencer emits one word per step while the output register is free.
// The input stalls until the last word: one for channel voice and DCTPQ, four for clip, tempo
// and time signature, up to MAX_CLOCKSTAMP_WORDS for a clockstamp; unknown items emit none.
// Reset returns the sequencer to idle and empties the output register.
`default_nettype none

module ump_event_word_encoder #(
  parameter int MAX_CLOCKSTAMP_WORDS = 63
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  func,
  input  wire  [3:0]  group,
  input  wire  [3:0]  channel,
  input  wire  [7:0]  key,
  input  wire  [7:0]  small_value,
  input  wire  [31:0] wide_value,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] word,
  output logic        last
);

  umpenc_pkg::dp_ctl_t ctl;
  logic                busy;
  logic                emit;
  logic                seq_last;
  logic                more;
  logic                out_free;
  logic [31:0]         dp_word;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  umpenc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .out_free  (out_free),
    .more      (more),
    .busy      (busy),
    .emit      (emit),
    .last_word (seq_last),
    .ctl       (ctl)
  );

  umpenc_dp #(
    .MAX_CLOCKSTAMP_WORDS (MAX_CLOCKSTAMP_WORDS)
  ) u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .func        (func),
    .group       (group),
    .channel     (channel),
    .key         (key),
    .small_value (small_value),
    .wide_value  (wide_value),
    .more        (more),
    .word        (dp_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word <= dp_word;
      last <= seq_last;
    end
  end

  a_known_func_runs: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func <= umpenc_pkg::FUNC_TIMESIG) |=> in_stall)
    else $error("known item did not start the sequencer");

  a_unknown_func_drops: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func > umpenc_pkg::FUNC_TIMESIG) |=> !in_stall)
    else $error("unknown item started the sequencer");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (emit && seq_last) |=> (!in_stall && out_valid && last))
    else $error("final word did not end the item");

endmodule

`default_nettype wire

// File: rtl/core/umpenc_dp.sv
`default_nettype none

module umpenc_dp #(
  parameter int MAX_CLOCKSTAMP_WORDS = 63
) (
  input  wire                     clk,
  input  umpenc_pkg::dp_ctl_t     ctl,
  input  wire  [3:0]              func,
  input  wire  [3:0]              group,
  input  wire  [3:0]              channel,
  input  wire  [7:0]              key,
  input  wire  [7:0]              small_value,
  input  wire  [31:0]             wide_value,
  output logic                    more,
  output logic [31:0]             word
);

  localparam int unsigned LIMIT  = MAX_CLOCKSTAMP_WORDS * 65535;
  localparam int          TICK_W = $clog2(LIMIT + 1);

  logic [3:0]        func_q;
  logic [3:0]        group_q;
  logic [3:0]        channel_q;
  logic [7:0]        key_q;
  logic [7:0]        sv_q;
  logic [31:0]       wv_q;
  logic [TICK_W-1:0] ticks;
  logic [38:0]       product;
  logic [38:0]       product_next;

  logic [3:0]  status;
  logic [6:0]  d1;
  logic [6:0]  d2;
  logic [13:0] bend;
  logic [15:0] tpq;
  logic [31:0] tempo;

  assign product_next = 39'(wv_q) * 39'(umpenc_pkg::TEMPO_SCALE);

  always_ff @(posedge clk) begin
    product <= product_next;
    if (ctl.load) begin
      func_q    <= func;
      group_q   <= group;
      channel_q <= channel;
      key_q     <= key;
      sv_q      <= small_value;
      wv_q      <= wide_value;
      ticks     <= (wide_value > 32'(LIMIT)) ? TICK_W'(LIMIT) : wide_value[TICK_W-1:0];
    end else if (ctl.tick_dec) begin
      ticks <= ticks - TICK_W'(umpenc_pkg::TICK_CHUNK);
    end
  end

  assign more  = ticks > TICK_W'(umpenc_pkg::TICK_CHUNK);
  assign bend  = (wv_q > 32'(umpenc_pkg::BEND_MAX)) ? umpenc_pkg::BEND_MAX : wv_q[13:0];
  assign tpq   = (wv_q > 32'(umpenc_pkg::TICK_CHUNK)) ? umpenc_pkg::TICK_CHUNK : wv_q[15:0];
  assign tempo = (product[38:32] != 7'd0) ? 32'hFFFF_FFFF : product[31:0];

  always_comb begin
    case (func_q)
      umpenc_pkg::FUNC_NOTE_ON:  status = umpenc_pkg::STATUS_NOTE_ON;
      umpenc_pkg::FUNC_NOTE_OFF: status = umpenc_pkg::STATUS_NOTE_OFF;
      umpenc_pkg::FUNC_PROGRAM:  status = umpenc_pkg::STATUS_PROGRAM;
      umpenc_pkg::FUNC_CC:       status = umpenc_pkg::STATUS_CC;
      default:                   status = umpenc_pkg::STATUS_BEND;
    endcase
    if (func_q == umpenc_pkg::FUNC_BEND) begin
      d1 = bend[6:0];
      d2 = bend[13:7];
    end else if (func_q == umpenc_pkg::FUNC_PROGRAM) begin
      d1 = key_q[6:0];
      d2 = 7'd0;
    end else begin
      d1 = key_q[6:0];
      d2 = sv_q[6:0];
    end
  end

  always_comb begin
    case (ctl.sel)
      umpenc_pkg::SEL_CV:
        word = {umpenc_pkg::MT_CV, group_q, status, channel_q, 1'b0, d1, 1'b0, d2};
      umpenc_pkg::SEL_STAMP:
        word = {4'h0, group_q, umpenc_pkg::STATUS_STAMP, 4'h0,
                more ? umpenc_pkg::TICK_CHUNK : ticks[15:0]};
      umpenc_pkg::SEL_DCTPQ:
        word = {8'h00, umpenc_pkg::STATUS_DCTPQ, 4'h0, tpq};
      umpenc_pkg::SEL_CLIP_START: word = umpenc_pkg::CLIP_START_HDR;
      umpenc_pkg::SEL_CLIP_END:   word = umpenc_pkg::CLIP_END_HDR;
      umpenc_pkg::SEL_TEMPO_HEAD: word = {umpenc_pkg::MT_FLEX, group_q, 24'h00_0000};
      umpenc_pkg::SEL_TEMPO_VAL:  word = tempo;
      umpenc_pkg::SEL_TSIG_HEAD:  word = {umpenc_pkg::MT_FLEX, group_q, 24'h00_0001};
      umpenc_pkg::SEL_TSIG_VAL:
        word = {key_q, 5'd0, umpenc_pkg::floor_log2(sv_q),
                umpenc_pkg::thirty_seconds(sv_q), 8'h00};
      default: word = 32'h0000_0000;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/umpenc_seq.sv
`default_nettype none

module umpenc_seq (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  wire  [3:0]              func,
  input  wire                     out_free,
  input  wire                     more,
  output logic                    busy,
  output logic                    emit,
  output logic                    last_word,
  output umpenc_pkg::dp_ctl_t     ctl
);

  umpenc_pkg::state_t state;
  umpenc_pkg::state_t state_next;
  umpenc_pkg::pc_t    pc;
  umpenc_pkg::pc_t    pc_next;
  umpenc_pkg::uword_t uw;
  umpenc_pkg::entry_t ent;

  assign uw  = umpenc_pkg::ucode(pc);
  assign ent = umpenc_pkg::entry(func);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= umpenc_pkg::ST_IDLE;
      pc    <= umpenc_pkg::PC_CV;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      umpenc_pkg::ST_IDLE: begin
        if (in_valid && ent.run) begin
          state_next = umpenc_pkg::ST_RUN;
          pc_next    = ent.pc;
        end
      end
      umpenc_pkg::ST_RUN: begin
        if (out_free) begin
          case (uw.seq)
            umpenc_pkg::SEQ_NEXT: pc_next = pc + umpenc_pkg::pc_t'(1);
            umpenc_pkg::SEQ_JUMP: pc_next = uw.target;
            umpenc_pkg::SEQ_LOOP: begin
              if (!more) begin
                state_next = umpenc_pkg::ST_IDLE;
              end
            end
            default: state_next = umpenc_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_next = umpenc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state == umpenc_pkg::ST_RUN);
    emit         = busy && out_free;
    last_word    = (uw.seq == umpenc_pkg::SEQ_END) ||
                   ((uw.seq == umpenc_pkg::SEQ_LOOP) && !more);
    ctl.load     = (state == umpenc_pkg::ST_IDLE) && in_valid;
    ctl.tick_dec = emit && (uw.seq == umpenc_pkg::SEQ_LOOP) && more;
    ctl.sel      = uw.sel;
  end

endmodule

`default_nettype wire
